/* rtl/gbre_pkg.sv */
// Shared types and constants for the glyph bitmap run-length encoder.
// Holds pixel classes, header bases and the command passed from front to back.
// No dependencies.
package gbre_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;   // run length 0..64
	localparam int MAX_RUN_DEF = 64;
	localparam int Q_DEPTH     = 4;

	localparam logic [BYTE_W-1:0] PIX_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] PIX_FULL = 8'hff;
	localparam logic [BYTE_W-1:0] HDR_ZERO = 8'h80;
	localparam logic [BYTE_W-1:0] HDR_FULL = 8'hc0;

	// Pixel / run class
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_ZERO = 2'd1,
		CLS_FULL = 2'd2,
		CLS_LIT  = 2'd3
	} cls_t;

	// One entry per input item that flushes something:
	// an optional earlier run (a) and an optional current run (b).
	typedef struct packed {
		logic             a_valid;
		cls_t             a_class;
		logic [LEN_W-1:0] a_len;
		logic             b_valid;
		cls_t             b_class;
		logic [LEN_W-1:0] b_len;
		logic             bank;   // literal bank of the flushed literal run
		logic             done;   // item closed the bitmap
	} cmd_t;

	// Back end hands a literal bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

/* rtl/gbre_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module gbre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/gbre_queue.sv */
// Small command queue between the front and back ends of the encoder.
// Depends on gbre_pkg for the command type.
module gbre_queue
	import gbre_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/gbre_front.sv */
// Front end: accepts pixels, classifies them, tracks the open run, stores
// literal bytes in a double-banked RAM and queues flush commands. Uses gbre_pkg.
module gbre_front
	import gbre_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF,
	localparam int IDX_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,
	input  logic                  s_tlast,
	input  logic                  q_full,
	input  rel_t                  rel,
	output logic                  q_push,
	output cmd_t                  q_cmd,
	output logic                  ram_we,
	output logic [IDX_W:0]        ram_waddr,
	output logic [BYTE_W-1:0]     ram_wdata
);

	cls_t             run_class_q;
	logic [LEN_W-1:0] run_len_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	cls_t             cls;
	logic             accept;
	logic             lit_open;
	logic             flush_a;
	logic             flush_b;
	logic [LEN_W-1:0] base_len;
	logic [LEN_W-1:0] new_len;
	logic             lit_flush;

	// pixel class
	always_comb begin
		if (s_tdata == PIX_ZERO) begin
			cls = CLS_ZERO;
		end else if (s_tdata == PIX_FULL) begin
			cls = CLS_FULL;
		end else begin
			cls = CLS_LIT;
		end
	end

	// stall when the command queue is full, or when a new literal run would land in a bank still being read
	assign lit_open = (run_class_q == CLS_LIT) && (run_len_q != '0);
	assign s_tready = !q_full && !(busy_q[bank_q] && !lit_open);
	assign accept   = s_tvalid && s_tready;

	// run bookkeeping
	assign flush_a   = (run_len_q != '0) && (run_class_q != cls);
	assign base_len  = flush_a ? '0 : run_len_q;
	assign new_len   = base_len + 1'b1;
	assign flush_b   = (new_len >= LEN_W'(MAX_RUN)) || s_tlast;
	assign lit_flush = (flush_a && (run_class_q == CLS_LIT)) || (flush_b && (cls == CLS_LIT));

	// literal byte store
	assign ram_we    = accept && (cls == CLS_LIT);
	assign ram_waddr = {bank_q, base_len[IDX_W-1:0]};
	assign ram_wdata = s_tdata;

	// flush command
	assign q_push        = accept && (flush_a || flush_b);
	assign q_cmd.a_valid = flush_a;
	assign q_cmd.a_class = run_class_q;
	assign q_cmd.a_len   = run_len_q;
	assign q_cmd.b_valid = flush_b;
	assign q_cmd.b_class = cls;
	assign q_cmd.b_len   = new_len;
	assign q_cmd.bank    = bank_q;
	assign q_cmd.done    = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_class_q <= CLS_NONE;
			run_len_q   <= '0;
			bank_q      <= 1'b0;
			busy_q      <= '0;
		end else begin
			if (accept) begin
				if (flush_b) begin
					run_class_q <= CLS_NONE;
					run_len_q   <= '0;
				end else begin
					run_class_q <= cls;
					run_len_q   <= new_len;
				end
				if (lit_flush) begin
					bank_q <= !bank_q;
				end
			end
			// bank release from the back end, then claim on a literal flush
			for (int b = 0; b < 2; b++) begin
				if (accept && lit_flush && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/gbre_back.sv */
// Back end: walks queued flush commands one encoded byte per cycle unless the output
// stalls, reads literal bytes from the RAM and packs up to two bytes per item. Uses gbre_pkg.
module gbre_back
	import gbre_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF,
	localparam int IDX_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  q_head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output rel_t                  rel,
	output logic                  ram_re,
	output logic [IDX_W:0]        ram_raddr,
	input  logic [BYTE_W-1:0]     ram_rdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2*BYTE_W-1:0]   m_tdata,
	output logic                  m_tlast,
	output logic [1:0]            m_tuser
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_A    = 3'b010,
		ST_B    = 3'b100
	} bstate_t;

	bstate_t          state_q;
	cmd_t             cmd_q;
	logic [LEN_W-1:0] pos_q;

	// byte stage
	logic              v_s2;
	logic [BYTE_W-1:0] hdr_s2;
	logic              lit_s2;
	logic              end_s2;
	logic              done_s2;

	// packer and output register
	logic              half_q;
	logic [BYTE_W-1:0] half_byte_q;
	logic              m_valid_q;
	logic [2*BYTE_W-1:0] m_data_q;
	logic              m_last_q;
	logic [1:0]        m_user_q;

	logic              active;
	logic              seg_b;
	cls_t              seg_class;
	logic [LEN_W-1:0]  seg_len;
	logic              seg_lit;
	logic              seg_end;
	logic              item_end;
	logic              adv;
	logic              step;
	logic              load;
	logic [LEN_W-1:0]  lit_idx;
	logic [BYTE_W-1:0] hdr;
	logic [BYTE_W-1:0] cur_byte;
	logic              emit;

	// current segment of the command
	assign active    = (state_q != ST_IDLE);
	assign seg_b     = (state_q == ST_B);
	assign seg_class = seg_b ? cmd_q.b_class : cmd_q.a_class;
	assign seg_len   = seg_b ? cmd_q.b_len : cmd_q.a_len;
	assign seg_lit   = (seg_class == CLS_LIT);
	assign seg_end   = !seg_lit || (pos_q == seg_len);
	assign item_end  = seg_end && (seg_b || !cmd_q.b_valid);

	assign adv   = !m_valid_q || m_tready;
	assign step  = active && adv;
	assign load  = (!active || (step && item_end)) && !q_empty;
	assign q_pop = load;

	// header byte of the current segment
	always_comb begin
		unique case (seg_class)
			CLS_ZERO: hdr = HDR_ZERO + BYTE_W'(seg_len) - 1'b1;
			CLS_FULL: hdr = HDR_FULL + BYTE_W'(seg_len) - 1'b1;
			CLS_LIT:  hdr = BYTE_W'(seg_len) - 1'b1;
			default:  hdr = '0;
		endcase
	end

	// literal reads; the bank goes back to the front with the last read
	assign lit_idx   = pos_q - 1'b1;
	assign ram_re    = step && seg_lit && (pos_q != '0);
	assign ram_raddr = {cmd_q.bank, lit_idx[IDX_W-1:0]};
	assign rel.valid = step && seg_lit && seg_end;
	assign rel.bank  = cmd_q.bank;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else if (load) begin
			state_q <= q_head.a_valid ? ST_A : ST_B;
			pos_q   <= '0;
		end else if (step) begin
			if (item_end) begin
				state_q <= ST_IDLE;
			end else if (seg_end) begin
				state_q <= ST_B;
				pos_q   <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_head;
		end
	end

	// byte stage, moves with the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_s2  <= hdr;
			lit_s2  <= seg_lit && (pos_q != '0);
			end_s2  <= item_end;
			done_s2 <= cmd_q.done;
		end
	end

	// pair packing
	assign cur_byte = lit_s2 ? ram_rdata : hdr_s2;
	assign emit     = v_s2 && (half_q || end_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= emit;
			if (v_s2) begin
				half_q <= !half_q && !end_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && !half_q) begin
			half_byte_q <= cur_byte;
		end
		if (adv && emit) begin
			m_data_q <= half_q ? {cur_byte, half_byte_q} : {{BYTE_W{1'b0}}, cur_byte};
			m_user_q <= {end_s2, half_q};
			m_last_q <= end_s2 && done_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

/* rtl/glyph_bitmap_rle_encoder_core.sv */
// Glyph bitmap run-length encoder, top level.
// Path: flushing pixel -> command queue -> back-end command register -> byte stage -> output register.
// Throughput: up to one pixel per cycle; the front stalls while the command queue is full or
// a new literal run needs a bank still being read. The back end makes one encoded byte per
// cycle (one RAM read port) while the output is not stalled.
// Reset: arst_n clears run state, queue and output; the literal RAM is not cleared.
module glyph_bitmap_rle_encoder_core
	import gbre_pkg::*;
#(
	parameter int MAX_RUN     = MAX_RUN_DEF,
	parameter int QUEUE_DEPTH = Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] pixel
	input  logic                s_tlast,   // end_of_bitmap
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [2*BYTE_W-1:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte
	output logic                m_tlast,   // stream_done
	output logic [1:0]          m_tuser    // [0] pair_valid, [1] last_of_burst
);

	localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int AW    = IDX_W + 1;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	cmd_t              q_cmd;
	cmd_t              q_head;
	rel_t              rel;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	gbre_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.rel       (rel),
		.q_push    (q_push),
		.q_cmd     (q_cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	gbre_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// two literal banks of MAX_RUN bytes (rounded up to a power of two)
	gbre_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gbre_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.rel       (rel),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTH
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("command popped from empty queue");

	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr[AW-1] != ram_raddr[AW-1]))
		else $error("literal write and read hit the same bank");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[1])
		else $error("bitmap end on an item that is not last of its burst");
`endif

endmodule
